// ===== design/hpe_pkg.sv =====
`default_nettype none

package hpe_pkg;

    // Command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ADD   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Sweep phases of an add request
    localparam logic PH_FIND   = 1'b0;
    localparam logic PH_UPDATE = 1'b1;

    // Index width covers the largest supported bin count plus the top edge
    localparam int IDX_W = 9;

    localparam logic [15:0] COUNT_SAT = 16'hFFFF;
    localparam logic [19:0] CUM_SAT   = 20'hFFFFF;
    localparam logic [31:0] TOTAL_SAT = 32'hFFFF_FFFF;
    localparam logic [15:0] MIN_RESET = 16'h7FFF;

    typedef logic [IDX_W-1:0] t_idx;

    // Request record that travels down the chain of cells
    typedef struct packed {
        logic               vld;
        logic               ph;
        logic [1:0]         cmd;
        t_idx               idx;
        logic signed [15:0] data;
        t_idx               nb;
        t_idx               last;
        logic               lo;
        logic               hi;
        logic               hit;
        t_idx               found;
        logic [15:0]        cnt;
        logic [19:0]        cum;
        logic [15:0]        newc;
    } t_rec;

endpackage

`default_nettype wire

// ===== design/hpe_if.sv =====
`default_nettype none

interface hpe_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [4:0]         bin_number;
    logic signed [15:0] data_value;

    modport source (output valid, output cmd, output bin_number, output data_value,
                    input ready);
    modport sink (input valid, input cmd, input bin_number, input data_value,
                  output ready);
endinterface

interface hpe_rsp_if;
    logic        valid;
    logic        ready;
    logic        bin_hit;
    logic [3:0]  bin_found;
    logic [15:0] count_out;
    logic [19:0] cumulative_out;
    logic [31:0] total_out;
    logic [15:0] max_out;
    logic [15:0] min_out;

    modport source (output valid, output bin_hit, output bin_found, output count_out,
                    output cumulative_out, output total_out, output max_out,
                    output min_out, input ready);
    modport sink (input valid, input bin_hit, input bin_found, input count_out,
                  input cumulative_out, input total_out, input max_out,
                  input min_out, output ready);
endinterface

`default_nettype wire

// ===== design/hpe_cell.sv =====
`default_nettype none

module hpe_cell #(
    parameter int CELL_ID = 0
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  hpe_pkg::t_rec      i_rec,
    input  wire signed [15:0]  i_next_edge,
    output hpe_pkg::t_rec      o_rec,
    output logic signed [15:0] o_edge
);

    localparam hpe_pkg::t_idx MY_ID = hpe_pkg::t_idx'(CELL_ID);

    hpe_pkg::t_rec      r_rec;
    hpe_pkg::t_rec      n_rec;
    logic signed [15:0] r_edge;
    logic signed [15:0] n_edge;
    logic [15:0]        r_count;
    logic [15:0]        n_count;
    logic [15:0]        w_inc;
    logic [20:0]        w_sum;

    assign w_inc = r_count + 16'd1;
    assign w_sum = {1'b0, i_rec.cum} + {5'd0, r_count};

    // Apply the request to this cell's edge and count, then pass it on
    always_comb begin
        n_rec   = i_rec;
        n_edge  = r_edge;
        n_count = r_count;
        if (i_rec.vld) begin
            case (i_rec.cmd)
                hpe_pkg::CMD_CLEAR: begin
                    n_count = '0;
                end
                hpe_pkg::CMD_WRITE: begin
                    if (i_rec.idx == MY_ID) begin
                        n_edge = i_rec.data;
                    end
                end
                hpe_pkg::CMD_ADD: begin
                    if (i_rec.ph == hpe_pkg::PH_FIND) begin
                        if (MY_ID == '0) begin
                            n_rec.lo = (i_rec.data >= r_edge);
                        end
                        if ((MY_ID < i_rec.nb) && (r_edge <= i_rec.data)) begin
                            n_rec.found = MY_ID;
                        end
                        if (MY_ID == i_rec.nb - hpe_pkg::t_idx'(1)) begin
                            n_rec.hi = (i_rec.data <= i_next_edge);
                        end
                    end else if (i_rec.hit && (i_rec.found == MY_ID)) begin
                        n_count    = (r_count == hpe_pkg::COUNT_SAT) ? r_count : w_inc;
                        n_rec.newc = n_count;
                    end
                end
                hpe_pkg::CMD_READ: begin
                    if (MY_ID <= i_rec.last) begin
                        n_rec.cum = w_sum[20] ? hpe_pkg::CUM_SAT : w_sum[19:0];
                    end
                    if ((MY_ID == i_rec.idx) && (i_rec.idx < i_rec.nb)) begin
                        n_rec.cnt = r_count;
                    end
                end
                default: begin
                    n_rec = i_rec;
                end
            endcase
        end
    end

    // Hold the count, the edge and the request stage; payload and edge carry no reset
    always_ff @(posedge i_clk) begin
        r_edge      <= n_edge;
        r_rec.ph    <= n_rec.ph;
        r_rec.cmd   <= n_rec.cmd;
        r_rec.idx   <= n_rec.idx;
        r_rec.data  <= n_rec.data;
        r_rec.nb    <= n_rec.nb;
        r_rec.last  <= n_rec.last;
        r_rec.lo    <= n_rec.lo;
        r_rec.hi    <= n_rec.hi;
        r_rec.hit   <= n_rec.hit;
        r_rec.found <= n_rec.found;
        r_rec.cnt   <= n_rec.cnt;
        r_rec.cum   <= n_rec.cum;
        r_rec.newc  <= n_rec.newc;
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rec.vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_rec.vld <= n_rec.vld;
        end
    end

    assign o_rec  = r_rec;
    assign o_edge = r_edge;

endmodule

`default_nettype wire

// ===== design/histogram_programmable_edges_top.sv =====
// Histogram with programmable bin edges.
// Requests arrive on i_req (valid/ready): cmd selects clear counts, write
// edge, add sample or read bin; bin_number and data_value carry the edge
// index, bin index, edge value or sample. Every request gives exactly one
// response on o_rsp (valid/ready) with hit flag, chosen bin, bin count,
// cumulative count and the running total, largest and smallest counts.
// i_cfg_we/i_cfg_data write the number of bins in use; write it only
// while no request is outstanding.
// Each bin lives in one cell of a chain; a request walks the chain one
// cell per cycle. Clear, write and read pass the launch register, the
// cells, the pending result and the output register; add walks the chain
// twice (find the bin, then bump its count), re-entering through the launch
// register. One request is in flight at a time, so i_req.ready rises with
// the edge that loads the previous response into the output register.
// Synchronous reset clears all counts and statistics and sets the bins in
// use to 16; edges are undefined until written.
// When the receiver stalls, the response waits in the output register; one
// more request may be accepted and finish behind it, and i_req.ready stays
// low from that acceptance until the waiting response is taken.
`default_nettype none

module histogram_programmable_edges_top #(
    parameter int MAX_BINS = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_cfg_we,
    input  wire [4:0] i_cfg_data,
    hpe_req_if.sink   i_req,
    hpe_rsp_if.source o_rsp
);

    localparam hpe_pkg::t_idx MB = hpe_pkg::t_idx'(MAX_BINS);

    logic [4:0]         r_bins;
    hpe_pkg::t_idx      w_bins;
    hpe_pkg::t_idx      w_nb;
    hpe_pkg::t_idx      w_idx;
    logic               r_busy;
    logic               r_pend;
    hpe_pkg::t_rec      r_launch;
    hpe_pkg::t_rec      n_launch;
    logic signed [15:0] r_top_edge;
    logic [31:0]        r_total;
    logic [15:0]        r_max;
    logic [15:0]        r_min;
    logic [31:0]        n_total;
    logic [15:0]        n_max;
    logic [15:0]        n_min;
    logic               w_accept;
    logic               w_out_free;
    logic               w_end_fin;
    hpe_pkg::t_rec      w_end;

    // Result waiting for the output register
    logic        r_res_hit;
    logic [3:0]  r_res_found;
    logic [15:0] r_res_cnt;
    logic [19:0] r_res_cum;
    logic [31:0] r_res_total;
    logic [15:0] r_res_max;
    logic [15:0] r_res_min;

    // Output register
    logic        r_ovld;
    logic        r_o_hit;
    logic [3:0]  r_o_found;
    logic [15:0] r_o_cnt;
    logic [19:0] r_o_cum;
    logic [31:0] r_o_total;
    logic [15:0] r_o_max;
    logic [15:0] r_o_min;

    hpe_pkg::t_rec      w_link [MAX_BINS+1];
    logic signed [15:0] w_edge [MAX_BINS+1];

    // Clamp bins in use to 1..MAX_BINS
    assign w_bins = hpe_pkg::t_idx'(r_bins);
    always_comb begin
        if (w_bins == '0) begin
            w_nb = hpe_pkg::t_idx'(1);
        end else if (w_bins > MB) begin
            w_nb = MB;
        end else begin
            w_nb = w_bins;
        end
    end

    assign w_idx       = hpe_pkg::t_idx'(i_req.bin_number);
    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && !r_busy;
    assign w_out_free  = !r_ovld || o_rsp.ready;
    assign w_end       = w_link[MAX_BINS];
    assign w_end_fin   = w_end.vld &&
                         !((w_end.cmd == hpe_pkg::CMD_ADD) && (w_end.ph == hpe_pkg::PH_FIND));

    // Build a new request, or send an add back through for its update pass
    always_comb begin
        n_launch     = r_launch;
        n_launch.vld = 1'b0;
        if (w_accept) begin
            n_launch.vld   = 1'b1;
            n_launch.ph    = hpe_pkg::PH_FIND;
            n_launch.cmd   = i_req.cmd;
            n_launch.idx   = w_idx;
            n_launch.data  = i_req.data_value;
            n_launch.nb    = w_nb;
            n_launch.last  = (w_idx < w_nb) ? w_idx : (w_nb - hpe_pkg::t_idx'(1));
            n_launch.lo    = 1'b0;
            n_launch.hi    = 1'b0;
            n_launch.hit   = 1'b0;
            n_launch.found = '0;
            n_launch.cnt   = '0;
            n_launch.cum   = '0;
            n_launch.newc  = '0;
        end else if (w_end.vld && !w_end_fin) begin
            n_launch     = w_end;
            n_launch.ph  = hpe_pkg::PH_UPDATE;
            n_launch.hit = w_end.lo && w_end.hi;
        end
    end

    // Update the statistics at the end of a request
    always_comb begin
        n_total = r_total;
        n_max   = r_max;
        n_min   = r_min;
        if (w_end_fin) begin
            if (w_end.cmd == hpe_pkg::CMD_CLEAR) begin
                n_total = '0;
                n_max   = '0;
                n_min   = hpe_pkg::MIN_RESET;
            end else if ((w_end.cmd == hpe_pkg::CMD_ADD) && w_end.hit) begin
                if (r_total != hpe_pkg::TOTAL_SAT) begin
                    n_total = r_total + 32'd1;
                end
                if (w_end.newc > r_max) begin
                    n_max = w_end.newc;
                end
                if (w_end.newc < r_min) begin
                    n_min = w_end.newc;
                end
            end
        end
    end

    // Control state and the launch stage; the launch payload carries no reset
    always_ff @(posedge i_clk) begin
        r_launch.ph    <= n_launch.ph;
        r_launch.cmd   <= n_launch.cmd;
        r_launch.idx   <= n_launch.idx;
        r_launch.data  <= n_launch.data;
        r_launch.nb    <= n_launch.nb;
        r_launch.last  <= n_launch.last;
        r_launch.lo    <= n_launch.lo;
        r_launch.hi    <= n_launch.hi;
        r_launch.hit   <= n_launch.hit;
        r_launch.found <= n_launch.found;
        r_launch.cnt   <= n_launch.cnt;
        r_launch.cum   <= n_launch.cum;
        r_launch.newc  <= n_launch.newc;
        if (!i_rst_n) begin
            r_bins       <= 5'd16;
            r_busy       <= 1'b0;
            r_pend       <= 1'b0;
            r_ovld       <= 1'b0;
            r_launch.vld <= 1'b0;
            r_total      <= '0;
            r_max        <= '0;
            r_min        <= hpe_pkg::MIN_RESET;
        end else begin
            if (i_cfg_we) begin
                r_bins <= i_cfg_data;
            end
            r_launch.vld <= n_launch.vld;
            r_total      <= n_total;
            r_max        <= n_max;
            r_min        <= n_min;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (r_pend && w_out_free) begin
                r_busy <= 1'b0;
            end
            if (w_end_fin) begin
                r_pend <= 1'b1;
            end else if (w_out_free) begin
                r_pend <= 1'b0;
            end
            if (r_pend && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req.cmd == hpe_pkg::CMD_WRITE) && (w_idx == MB)) begin
            r_top_edge <= i_req.data_value;
        end
        if (w_end_fin) begin
            r_res_hit   <= (w_end.cmd == hpe_pkg::CMD_ADD) && w_end.hit;
            r_res_found <= ((w_end.cmd == hpe_pkg::CMD_ADD) && w_end.hit) ?
                           w_end.found[3:0] : 4'd0;
            r_res_cnt   <= w_end.cnt;
            r_res_cum   <= w_end.cum;
            r_res_total <= n_total;
            r_res_max   <= n_max;
            r_res_min   <= n_min;
        end
        if (r_pend && w_out_free) begin
            r_o_hit   <= r_res_hit;
            r_o_found <= r_res_found;
            r_o_cnt   <= r_res_cnt;
            r_o_cum   <= r_res_cum;
            r_o_total <= r_res_total;
            r_o_max   <= r_res_max;
            r_o_min   <= r_res_min;
        end
    end

    // Chain of bin cells
    assign w_link[0]        = r_launch;
    assign w_edge[MAX_BINS] = r_top_edge;

    for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
        hpe_cell #(
            .CELL_ID (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_rec       (w_link[k]),
            .i_next_edge (w_edge[k+1]),
            .o_rec       (w_link[k+1]),
            .o_edge      (w_edge[k])
        );
    end

    assign o_rsp.valid          = r_ovld;
    assign o_rsp.bin_hit        = r_o_hit;
    assign o_rsp.bin_found      = r_o_found;
    assign o_rsp.count_out      = r_o_cnt;
    assign o_rsp.cumulative_out = r_o_cum;
    assign o_rsp.total_out      = r_o_total;
    assign o_rsp.max_out        = r_o_max;
    assign o_rsp.min_out        = r_o_min;

    // A record in the chain means a request is outstanding
    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.vld |-> r_busy)
        else $error("request launched while idle");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.vld |-> (r_busy && !r_pend))
        else $error("chain output without an outstanding request");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("pending result while idle");

    a_one_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !w_end.vld)
        else $error("second record in the chain");

    a_miss_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !r_o_hit) |-> (r_o_found == 4'd0))
        else $error("bin reported without a hit");

endmodule

`default_nettype wire

// ===== tb/tb_histogram_programmable_edges_top.sv =====
`timescale 1ns / 100ps

module tb_histogram_programmable_edges_top;

    localparam int NUM_BINS        = 16;
    localparam int EDGE_CNT        = NUM_BINS + 1;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER_RSP  = 150;
    localparam int SETTLE_CYCLES   = 2 * NUM_BINS + 8;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [4:0]         idx;
        logic signed [15:0] data;
    } t_hist_req;

    typedef struct packed {
        logic        hit;
        logic [3:0]  found;
        logic [15:0] cnt;
        logic [19:0] cum;
        logic [31:0] total;
        logic [15:0] peak;
        logic [15:0] floor;
    } t_hist_stats;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [4:0] i_cfg_data = '0;

    hpe_req_if req_ch();
    hpe_rsp_if rsp_ch();

    histogram_programmable_edges_top #(
        .MAX_BINS(NUM_BINS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Shadow of the histogram state, updated as requests are accepted
    logic signed [15:0] edge_mem [EDGE_CNT];
    logic [15:0]        bin_cnt  [NUM_BINS];
    logic [31:0]        total_cnt;
    logic [15:0]        peak_cnt;
    logic [15:0]        floor_cnt;
    logic [4:0]         bins_reg;

    // Request backlog and predicted response stream
    t_hist_req   cmd_backlog[$];
    t_hist_stats predicted_stats[$];
    int          cmds_queued     = 0;
    int          cmds_accepted   = 0;
    int          rsp_seen        = 0;
    int          stats_mismatches = 0;
    int          cycle_cnt       = 0;

    // Edge table as the queued writes will leave it, for sample selection
    int gen_edges [EDGE_CNT];
    int gen_n;

    logic req_taken  = 1'b0;
    logic rsp_taken  = 1'b0;
    logic rsp_hold   = 1'b0;
    logic gaps_on    = 1'b1;
    int   send_wait  = 0;
    int   rsp_stall  = 0;

    always #1 i_clk = ~i_clk;

    function automatic void clear_stats();
        for (int i = 0; i < NUM_BINS; i++) bin_cnt[i] = '0;
        total_cnt = '0;
        peak_cnt  = '0;
        floor_cnt = hpe_pkg::MIN_RESET;
    endfunction

    // Apply one request to the shadow state and return the response it gives
    function automatic t_hist_stats histogram_step(t_hist_req rq);
        t_hist_stats res;
        int          n;
        int          last;
        int          sum;
        logic [15:0] c;
        res = '0;
        n = (bins_reg == 0) ? 1 : ((bins_reg > NUM_BINS) ? NUM_BINS : int'(bins_reg));
        case (rq.cmd)
            hpe_pkg::CMD_CLEAR: begin
                clear_stats();
            end
            hpe_pkg::CMD_WRITE: begin
                if (rq.idx <= NUM_BINS) edge_mem[rq.idx] = rq.data;
            end
            hpe_pkg::CMD_ADD: begin
                if (rq.data >= edge_mem[0] && rq.data <= edge_mem[n]) begin
                    // Pick the highest qualifying bin, bin 0 always qualifies
                    for (int i = 0; i < n; i++) begin
                        if (edge_mem[i] <= rq.data) res.found = 4'(i);
                    end
                    res.hit = 1'b1;
                    c = bin_cnt[res.found];
                    if (c != hpe_pkg::COUNT_SAT) c = c + 16'd1;
                    bin_cnt[res.found] = c;
                    if (total_cnt != hpe_pkg::TOTAL_SAT) total_cnt = total_cnt + 32'd1;
                    if (c > peak_cnt) peak_cnt = c;
                    if (c < floor_cnt) floor_cnt = c;
                end
            end
            default: begin
                last = (rq.idx < n) ? int'(rq.idx) : n - 1;
                sum = 0;
                for (int i = 0; i <= last; i++) sum += int'(bin_cnt[i]);
                res.cum = (sum > int'(hpe_pkg::CUM_SAT)) ? hpe_pkg::CUM_SAT : 20'(sum);
                res.cnt = (rq.idx < n) ? bin_cnt[rq.idx] : 16'd0;
            end
        endcase
        res.total = total_cnt;
        res.peak  = peak_cnt;
        res.floor = floor_cnt;
        return res;
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            stats_mismatches++;
            if (stats_mismatches <= MAX_REPORTS)
                $display("%t %s mismatch: expected %0d, got %0d", $realtime, name, want_v, got_v);
        end
    endtask

    task automatic queue_cmd(logic [1:0] op, int idx, int val);
        t_hist_req it;
        it.cmd  = op;
        it.idx  = 5'(idx);
        it.data = 16'(val);
        if (op == hpe_pkg::CMD_WRITE && it.idx <= NUM_BINS) gen_edges[it.idx] = it.data;
        cmd_backlog.push_back(it);
        cmds_queued++;
    endtask

    task automatic queue_edges_linear(int start, int step);
        int v;
        for (int i = 0; i < EDGE_CNT; i++) begin
            v = start + step * i;
            if (v > 32767) v = 32767;
            queue_cmd(hpe_pkg::CMD_WRITE, i, v);
        end
    endtask

    // Increasing edges with random spacing, equal neighbors now and then
    task automatic queue_edges_random();
        int v;
        v = int'($urandom_range(40000)) - 32768;
        for (int i = 0; i < EDGE_CNT; i++) begin
            if (i > 0) v = v + int'($urandom_range(2500));
            if (v > 32767) v = 32767;
            queue_cmd(hpe_pkg::CMD_WRITE, i, v);
        end
    endtask

    task automatic queue_random_item();
        int r;
        int s;
        int lo;
        int hi;
        int idx;
        int v;
        r  = $urandom_range(99);
        lo = gen_edges[0];
        hi = gen_edges[gen_n];
        v  = int'($urandom_range(65535)) - 32768;
        if (r < 3) begin
            queue_cmd(hpe_pkg::CMD_CLEAR, $urandom_range(31), v);
        end else if (r < 10) begin
            // Edge rewrite: mostly keeps the order, sometimes scrambles it
            idx = ($urandom_range(9) == 0) ? $urandom_range(31, 17) : $urandom_range(NUM_BINS);
            if (idx >= 1 && idx < NUM_BINS && gen_edges[idx - 1] <= gen_edges[idx + 1]
                && $urandom_range(3) != 0)
                v = gen_edges[idx - 1] + int'($urandom_range(gen_edges[idx + 1] - gen_edges[idx - 1]));
            queue_cmd(hpe_pkg::CMD_WRITE, idx, v);
        end else if (r < 75) begin
            s = $urandom_range(19);
            if (s < 15 && lo <= hi) v = lo + int'($urandom_range(hi - lo));
            else if (s < 17) v = gen_edges[$urandom_range(gen_n)];
            queue_cmd(hpe_pkg::CMD_ADD, $urandom_range(31), v);
        end else begin
            idx = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(gen_n - 1);
            queue_cmd(hpe_pkg::CMD_READ, idx, v);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmds_accepted != cmds_queued || predicted_stats.size() != 0);
    endtask

    task automatic write_bins(int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 5'(val);
        gen_n = (val == 0) ? 1 : ((val > NUM_BINS) ? NUM_BINS : val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Request driver: hold until taken, then idle for the chosen gap
    always @(negedge i_clk) begin : req_source
        t_hist_req item;
        if (!i_rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.cmd        <= hpe_pkg::CMD_CLEAR;
            req_ch.bin_number <= '0;
            req_ch.data_value <= '0;
        end else if (!req_ch.valid || req_taken) begin
            if (send_wait > 0) begin
                req_ch.valid <= 1'b0;
                send_wait    <= send_wait - 1;
            end else if (cmd_backlog.size() > 0) begin
                item = cmd_backlog.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.cmd        <= item.cmd;
                req_ch.bin_number <= item.idx;
                req_ch.data_value <= item.data;
                send_wait         <= pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Track config writes and predict each accepted request
    always @(posedge i_clk) begin : req_predict
        t_hist_req rq;
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (!i_rst_n) begin
            clear_stats();
            bins_reg = 5'd16;
        end else begin
            if (i_cfg_we) bins_reg = i_cfg_data;
            if (req_ch.valid && req_ch.ready) begin
                rq.cmd  = req_ch.cmd;
                rq.idx  = req_ch.bin_number;
                rq.data = req_ch.data_value;
                predicted_stats.push_back(histogram_step(rq));
                cmds_accepted++;
            end
        end
    end

    // Response sink: random stalls after each take, plus the long hold-off
    always @(negedge i_clk) begin : rsp_sink
        int gap;
        gap = rsp_taken ? pick_gap() : 0;
        if (!i_rst_n || rsp_hold) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
        end else if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= gap - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Check each taken response against the oldest prediction
    always @(posedge i_clk) begin : rsp_check
        t_hist_stats got;
        t_hist_stats want;
        rsp_taken <= i_rst_n && rsp_ch.valid && rsp_ch.ready;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (predicted_stats.size() == 0) begin
                stats_mismatches++;
                if (stats_mismatches <= MAX_REPORTS)
                    $display("%t response with no request outstanding", $realtime);
            end else begin
                want = predicted_stats.pop_front();
                got.hit   = rsp_ch.bin_hit;
                got.found = rsp_ch.bin_found;
                got.cnt   = rsp_ch.count_out;
                got.cum   = rsp_ch.cumulative_out;
                got.total = rsp_ch.total_out;
                got.peak  = rsp_ch.max_out;
                got.floor = rsp_ch.min_out;
                compare_field("bin_hit", 32'(want.hit), 32'(got.hit));
                compare_field("bin_found", 32'(want.found), 32'(got.found));
                compare_field("count_out", 32'(want.cnt), 32'(got.cnt));
                compare_field("cumulative_out", 32'(want.cum), 32'(got.cum));
                compare_field("total_out", want.total, got.total);
                compare_field("max_out", 32'(want.peak), 32'(got.peak));
                compare_field("min_out", 32'(want.floor), 32'(got.floor));
            end
        end
    end

    // Long receiver hold-off so the block backs up and drops ready
    initial begin : rsp_holdoff
        wait (rsp_seen >= HOLD_AFTER_RSP);
        @(negedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rsp_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_histogram_programmable_edges_top: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int bins_plan [8];
        bins_plan = '{1, 0, 16, 31, 9, 17, 0, 0};
        bins_plan[6] = $urandom_range(16, 1);
        bins_plan[7] = $urandom_range(31);
        gen_n = NUM_BINS;
        for (int i = 0; i < EDGE_CNT; i++) gen_edges[i] = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: evenly spaced edges, then the boundary cases
        queue_edges_linear(-30000, 3750);
        queue_cmd(hpe_pkg::CMD_WRITE, 31, -32768);     // edge index out of range, dropped
        queue_cmd(hpe_pkg::CMD_WRITE, 17, 32767);      // just past the top edge, dropped
        queue_cmd(hpe_pkg::CMD_ADD, 0, -32768);        // below edge 0
        queue_cmd(hpe_pkg::CMD_ADD, 31, 32767);        // above the top edge
        queue_cmd(hpe_pkg::CMD_ADD, 0, -30000);        // exactly edge 0
        queue_cmd(hpe_pkg::CMD_ADD, 0, 30000);         // top edge is inclusive
        queue_cmd(hpe_pkg::CMD_ADD, 0, -26250);        // lower edge of bin 1
        queue_cmd(hpe_pkg::CMD_READ, 0, 0);
        queue_cmd(hpe_pkg::CMD_READ, 15, 0);
        queue_cmd(hpe_pkg::CMD_READ, 31, -1);          // past the bins in use
        queue_cmd(hpe_pkg::CMD_CLEAR, 31, -1);
        queue_cmd(hpe_pkg::CMD_READ, 15, 0);
        queue_cmd(hpe_pkg::CMD_ADD, 0, 0);
        wait_idle();

        // Random phases, each with its own bin count and fresh edge set
        for (int p = 0; p < 8; p++) begin
            write_bins(bins_plan[p]);
            gaps_on = (p != 2);
            if (p == 0) queue_edges_linear(-32768, 4096);
            else queue_edges_random();
            repeat (ITEMS_PER_PHASE) queue_random_item();
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (stats_mismatches == 0) begin
            $display("tb_histogram_programmable_edges_top: done, clean");
        end else begin
            $display("tb_histogram_programmable_edges_top: done, errors");
        end
        $finish;
    end

endmodule
